### hw/rtl/rgbpm_pkg.sv
// Shared types and constants for the RGB pixel multiplier.
// Holds the pixel payload structs, mode codes and register indexes.
// No dependencies.
package rgbpm_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_CUSTOM = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_RED   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_GREEN = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_BLUE  = 8'd4;

    // Unity gain in Q8.8.
    localparam logic signed [15:0] GAIN_UNITY = 16'sd256;

    // Fixed transform modes.
    typedef enum logic [2:0] {
        MODE_INFINITY = 3'd0,
        MODE_X8       = 3'd1,
        MODE_X4       = 3'd2,
        MODE_X2       = 3'd3,
        MODE_HALF     = 3'd4,
        MODE_QUARTER  = 3'd5,
        MODE_EIGHTH   = 3'd6,
        MODE_ZERO     = 3'd7
    } t_mode;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } t_pixel_out;

endpackage

### hw/rtl/rgb_pixel_multiplier_top.sv
// RGB pixel multiplier: three-stage pipeline with per-channel gain or fixed modes.
// Depends on rgbpm_pkg for payload structs, mode codes and register indexes.
//
// Usage:
// The input channel (i_in_valid / o_in_ready / i_in_data) takes one RGBA pixel
// per transaction; the output channel (o_out_valid / i_out_ready / o_out_data)
// returns one transformed pixel per input, in order. Alpha is copied through.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes register
// i_cfg_index with i_cfg_data; it is always ready and unknown indexes are
// ignored. Registers should only change while the pipeline is empty.
// Throughput is one pixel per cycle while the receiver accepts; the stages are
// input capture, the 9x16 signed gain multipliers, and clamp/round/select into
// the output register. When the receiver stalls, every full stage holds its
// contents and the input stays ready as long as an empty stage remains ahead
// of it; nothing is lost or repeated. Synchronous active-low reset empties the
// pipeline and sets mode infinity, custom gains off and all gains to unity.
module rgb_pixel_multiplier_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  rgbpm_pkg::t_pixel_in               i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output rgbpm_pkg::t_pixel_out              o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rgbpm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rgbpm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Configuration registers.
    rgbpm_pkg::t_mode   r_mode;
    logic               r_use_custom;
    logic signed [15:0] r_gain [3];

    // Pipeline valid bits and payload.
    logic                  r_v1, r_v2, r_v3;
    rgbpm_pkg::t_pixel_in  r1_pix;
    logic signed [24:0]    r2_prod [3];
    rgbpm_pkg::t_pixel_out r2_fixed;
    logic [7:0]            r2_alpha;
    logic                  r2_custom;
    rgbpm_pkg::t_pixel_out r3_pix;

    logic en1, en2, en3;
    logic [7:0] s1_ch [3];
    logic signed [24:0] n_prod [3];
    rgbpm_pkg::t_pixel_out n_fixed;
    logic [7:0] n_gain_ch [3];
    rgbpm_pkg::t_pixel_out n_out;

    // Saturating left shift of a channel, clipped at 255.
    function automatic logic [7:0] sat_shl(input logic [7:0] ch, input logic [1:0] sh);
        logic [10:0] wide;
        wide = {3'b000, ch} << sh;
        return (wide >= 11'd255) ? 8'd255 : wide[7:0];
    endfunction

    // Clamp a signed Q16.8 product to 0..255.0 and round half up to a byte.
    function automatic logic [7:0] clamp_round(input logic signed [24:0] p);
        logic [16:0] sum;
        sum = {1'b0, p[15:0]} + 17'd128;
        if (p[24]) begin
            return 8'd0;
        end else if (p >= 25'sd65280) begin
            return 8'd255;
        end else begin
            return sum[15:8];
        end
    endfunction

    // Stall control: a stage advances when it is empty or the next one moves.
    assign en3        = !r_v3 || i_out_ready;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_ready = en1;
    assign o_cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= rgbpm_pkg::MODE_INFINITY;
            r_use_custom <= 1'b0;
            r_gain[0]    <= rgbpm_pkg::GAIN_UNITY;
            r_gain[1]    <= rgbpm_pkg::GAIN_UNITY;
            r_gain[2]    <= rgbpm_pkg::GAIN_UNITY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rgbpm_pkg::REG_MODE:       r_mode <= rgbpm_pkg::t_mode'(i_cfg_data[2:0]);
                rgbpm_pkg::REG_USE_CUSTOM: r_use_custom <= i_cfg_data[0];
                rgbpm_pkg::REG_GAIN_RED:   r_gain[0] <= $signed(i_cfg_data);
                rgbpm_pkg::REG_GAIN_GREEN: r_gain[1] <= $signed(i_cfg_data);
                rgbpm_pkg::REG_GAIN_BLUE:  r_gain[2] <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // Stage 2 inputs: gain products and the fixed-mode result.
    assign s1_ch[0] = r1_pix.red_in;
    assign s1_ch[1] = r1_pix.green_in;
    assign s1_ch[2] = r1_pix.blue_in;

    always_comb begin
        logic [7:0] v;
        logic       all_white;
        for (int i = 0; i < 3; i++) begin
            n_prod[i] = $signed({1'b0, s1_ch[i]}) * r_gain[i];
        end
        v = ((s1_ch[0] | s1_ch[1] | s1_ch[2]) != 8'd0) ? 8'd255 : 8'd0;
        all_white = (s1_ch[0] == 8'd255) && (s1_ch[1] == 8'd255) && (s1_ch[2] == 8'd255);
        n_fixed.alpha_out = r1_pix.alpha_in;
        case (r_mode)
            rgbpm_pkg::MODE_INFINITY: begin
                n_fixed.red_out   = v;
                n_fixed.green_out = v;
                n_fixed.blue_out  = v;
            end
            rgbpm_pkg::MODE_X8: begin
                n_fixed.red_out   = sat_shl(s1_ch[0], 2'd3);
                n_fixed.green_out = sat_shl(s1_ch[1], 2'd3);
                n_fixed.blue_out  = sat_shl(s1_ch[2], 2'd3);
            end
            rgbpm_pkg::MODE_X4: begin
                n_fixed.red_out   = sat_shl(s1_ch[0], 2'd2);
                n_fixed.green_out = sat_shl(s1_ch[1], 2'd2);
                n_fixed.blue_out  = sat_shl(s1_ch[2], 2'd2);
            end
            rgbpm_pkg::MODE_X2: begin
                n_fixed.red_out   = sat_shl(s1_ch[0], 2'd1);
                n_fixed.green_out = sat_shl(s1_ch[1], 2'd1);
                n_fixed.blue_out  = sat_shl(s1_ch[2], 2'd1);
            end
            rgbpm_pkg::MODE_HALF: begin
                n_fixed.red_out   = s1_ch[0] >> 1;
                n_fixed.green_out = s1_ch[1] >> 1;
                n_fixed.blue_out  = s1_ch[2] >> 1;
            end
            rgbpm_pkg::MODE_QUARTER: begin
                n_fixed.red_out   = s1_ch[0] >> 2;
                n_fixed.green_out = s1_ch[1] >> 2;
                n_fixed.blue_out  = s1_ch[2] >> 2;
            end
            rgbpm_pkg::MODE_EIGHTH: begin
                n_fixed.red_out   = s1_ch[0] >> 3;
                n_fixed.green_out = s1_ch[1] >> 3;
                n_fixed.blue_out  = s1_ch[2] >> 3;
            end
            default: begin
                // Zero mode keeps only a pure white pixel.
                n_fixed.red_out   = all_white ? s1_ch[0] : 8'd0;
                n_fixed.green_out = all_white ? s1_ch[1] : 8'd0;
                n_fixed.blue_out  = all_white ? s1_ch[2] : 8'd0;
            end
        endcase
    end

    // Stage 3 inputs: clamp, round and choose between gain and fixed paths.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_gain_ch[i] = clamp_round(r2_prod[i]);
        end
        if (r2_custom) begin
            n_out.red_out   = n_gain_ch[0];
            n_out.green_out = n_gain_ch[1];
            n_out.blue_out  = n_gain_ch[2];
            n_out.alpha_out = r2_alpha;
        end else begin
            n_out = r2_fixed;
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_pix <= i_in_data;
        end
        if (en2) begin
            r2_prod[0] <= n_prod[0];
            r2_prod[1] <= n_prod[1];
            r2_prod[2] <= n_prod[2];
            r2_fixed   <= n_fixed;
            r2_alpha   <= r1_pix.alpha_in;
            r2_custom  <= r_use_custom;
        end
        if (en3) begin
            r3_pix <= n_out;
        end
    end

    assign o_out_valid = r_v3;
    assign o_out_data  = r3_pix;

endmodule
